// ----- hdl/lprd_pkg.sv -----
// ----------------------------------------------------------------------------
// Length-prefixed record deframer package
// Shared types and character constants for the deframer modules.
// ----------------------------------------------------------------------------
package lprd_pkg;

  localparam int unsigned MAX_LEN_W = 16;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 16'hFFFF;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_KEY_PREFIX = 4'b0001,
    PH_KEY_BODY   = 4'b0010,
    PH_VAL_PREFIX = 4'b0100,
    PH_VAL_BODY   = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_PREFIX    = 3'd1,
    ST_OVERFLOW      = 3'd2,
    ST_MISSING_VALUE = 3'd3,
    ST_TRUNCATED     = 3'd4,
    ST_TRAILING      = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } item_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       is_value;
    logic       field_done;
    logic       string_done;
    status_e    status;
  } result_t;

endpackage

// ----- hdl/lprd_in_stage.sv -----
// ----------------------------------------------------------------------------
// Deframer input stage
// Registers one incoming byte; refills in the same cycle it is consumed.
// ----------------------------------------------------------------------------
module lprd_in_stage
  import lprd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  take_i,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;
  logic  load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- hdl/lprd_core.sv -----
// ----------------------------------------------------------------------------
// Deframer parse core
// Holds the phase, prefix accumulator, body counter, sticky error and the
// max_len register; works out the result for one byte per cycle while fire_i is high.
// ----------------------------------------------------------------------------
module lprd_core
  import lprd_pkg::*;
#(
  parameter int unsigned LEN_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [MAX_LEN_W-1:0] cfg_wdata_i,
  input  logic                 fire_i,
  input  item_t                item_i,
  output logic                 emit_o,
  output result_t              result_o
);

  localparam int unsigned AW = LEN_WIDTH + 1;
  localparam int unsigned PW = LEN_WIDTH + 5;
  localparam int unsigned CW = (LEN_WIDTH > MAX_LEN_W) ? LEN_WIDTH : MAX_LEN_W;

  logic [MAX_LEN_W-1:0] max_len_q;
  phase_e               phase_q, phase_d;
  logic [AW-1:0]        acc_q, acc_d;
  logic                 seen_q, seen_d;
  logic [LEN_WIDTH-1:0] left_q, left_d;
  status_e              err_q, err_d;

  logic [CW-1:0]        max_ext, cap;
  logic [LEN_WIDTH-1:0] limit;
  logic [PW-1:0]        prod;
  logic                 is_digit, over, val_side;
  status_e              end_status;
  logic [7:0]           ch;

  assign ch      = item_i.data_byte;
  assign max_ext = CW'(max_len_q);
  assign cap     = {CW{1'b1}} >> (CW - LEN_WIDTH);
  assign limit   = (max_ext < cap) ? max_ext[LEN_WIDTH-1:0] : cap[LEN_WIDTH-1:0];

  assign is_digit = ch inside {[CHAR_ZERO:CHAR_NINE]};
  // acc * 10 + digit; the low nibble of an ASCII digit is its value
  assign prod     = PW'({acc_q, 3'b000}) + PW'({acc_q, 1'b0}) + PW'(ch[3:0]);
  assign over     = prod > PW'(limit);
  assign val_side = phase_q inside {PH_VAL_PREFIX, PH_VAL_BODY};

  always_comb begin
    phase_d    = phase_q;
    acc_d      = acc_q;
    seen_d     = seen_q;
    left_d     = left_q;
    err_d      = err_q;
    emit_o     = 1'b0;
    result_o   = '0;
    end_status = ST_OK;

    if (err_q == ST_OK) begin
      case (phase_q)
        PH_KEY_PREFIX, PH_VAL_PREFIX: begin
          if (is_digit) begin
            seen_d = 1'b1;
            if (over) begin
              acc_d = AW'(limit) + AW'(1);
              err_d = ST_OVERFLOW;
            end else begin
              acc_d = prod[AW-1:0];
            end
          end else if (ch == CHAR_COLON && seen_q) begin
            acc_d  = '0;
            seen_d = 1'b0;
            if (acc_q == '0) begin
              emit_o              = 1'b1;
              result_o.is_value   = val_side;
              result_o.field_done = 1'b1;
              phase_d             = val_side ? PH_KEY_PREFIX : PH_VAL_PREFIX;
            end else begin
              left_d  = acc_q[LEN_WIDTH-1:0];
              phase_d = val_side ? PH_VAL_BODY : PH_KEY_BODY;
            end
          end else begin
            err_d = ST_BAD_PREFIX;
          end
        end
        PH_KEY_BODY, PH_VAL_BODY: begin
          emit_o            = 1'b1;
          result_o.has_byte = 1'b1;
          result_o.out_byte = ch;
          result_o.is_value = val_side;
          left_d            = left_q - LEN_WIDTH'(1);
          if (left_q == LEN_WIDTH'(1)) begin
            result_o.field_done = 1'b1;
            phase_d             = val_side ? PH_KEY_PREFIX : PH_VAL_PREFIX;
          end
        end
        default: ;
      endcase
    end

    if (item_i.end_of_string) begin
      end_status = err_d;
      if (err_d == ST_OK) begin
        if (phase_d == PH_VAL_PREFIX) begin
          end_status = ST_MISSING_VALUE;
        end else if (phase_d inside {PH_KEY_BODY, PH_VAL_BODY}) begin
          end_status = ST_TRUNCATED;
        end else if (seen_d) begin
          end_status = ST_TRAILING;
        end
      end
      emit_o               = 1'b1;
      result_o.string_done = 1'b1;
      result_o.status      = end_status;
      phase_d              = PH_KEY_PREFIX;
      acc_d                = '0;
      seen_d               = 1'b0;
      left_d               = '0;
      err_d                = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_KEY_PREFIX;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      left_q  <= '0;
      err_q   <= ST_OK;
    end else if (fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      left_q  <= left_d;
      err_q   <= err_d;
    end
  end

`ifndef ASSERT_OFF
  a_body_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q == ST_OK && (phase_q == PH_KEY_BODY || phase_q == PH_VAL_BODY))
      |-> left_q != '0)
    else $error("body phase with no bytes left");

  a_accum_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q == ST_OK && !cfg_we_i && !$past(cfg_we_i)) |-> acc_q <= AW'(limit))
    else $error("length accumulator above limit without error");

  a_digit_only_in_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (phase_q == PH_KEY_PREFIX || phase_q == PH_VAL_PREFIX))
    else $error("prefix digit flag outside a prefix");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.end_of_string)
      |=> (phase_q == PH_KEY_PREFIX && err_q == ST_OK && !seen_q))
    else $error("string end did not clear parser state");
`endif

endmodule

// ----- hdl/lprd_out_stage.sv -----
// ----------------------------------------------------------------------------
// Deframer output stage
// Result register; holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module lprd_out_stage
  import lprd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ----- hdl/length_prefix_record_deframer.sv -----
// ----------------------------------------------------------------------------
// Length-prefixed record deframer
// Splits a "<len>:<body>" key/value byte stream into tagged body bytes.
//
//   channel   | dir | payload
//   ----------+-----+-------------------------------------------------------
//   s_axis    | in  | tdata: data_byte; tlast: end_of_string
//   m_axis    | out | tdata: out_byte, status; tlast: field_done;
//             |     | tuser: has_byte, is_value, string_done
//   cfg       | in  | cfg_wdata_i: max_len, written when cfg_we_i is high
//
// One byte per cycle while the output is not stalled; each byte passes the input
// register, then the parse core into the result register.
// rst_ni clears the parser and sets max_len to 65535.
// A stalled output holds one result; the input register still takes the
// next byte and holds it until the result register frees.
// ----------------------------------------------------------------------------
module length_prefix_record_deframer
  import lprd_pkg::*;
#(
  parameter int unsigned LEN_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [MAX_LEN_W-1:0] cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // [7:0] out_byte, [10:8] status
  output logic                 m_axis_tlast,
  output logic [2:0]           m_axis_tuser    // [0] has_byte, [1] is_value,
                                               // [2] string_done
);

  item_t   in_item, core_item;
  result_t core_res, out_res;
  logic    core_valid, core_emit, out_free, fire;

  assign in_item.data_byte     = s_axis_tdata;
  assign in_item.end_of_string = s_axis_tlast;

  assign fire = core_valid && out_free;

  lprd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (core_valid),
    .take_i  (fire),
    .item_o  (core_item)
  );

  lprd_core #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (core_item),
    .emit_o      (core_emit),
    .result_o    (core_res)
  );

  lprd_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire && core_emit),
    .result_i (core_res),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_res)
  );

  assign m_axis_tdata = {5'b00000, out_res.status, out_res.out_byte};
  assign m_axis_tlast = out_res.field_done;
  assign m_axis_tuser = {out_res.string_done, out_res.is_value, out_res.has_byte};

endmodule
